FILE: src/wcm_pkg.sv
// ----------------------------------------------------------------------------
// Weighted circular mean package
// Shared widths, control structures, sequencer states and the CORDIC arctangent
// table for the weighted circular mean block.
// ----------------------------------------------------------------------------
package wcm_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int ACCUM_BITS   = 48;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int STEPS        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int CNT_W        = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int TBL_IDX_W    = $clog2(TABLE_LEN);

	localparam int PHASE_BITS   = 32;
	localparam int XW           = 34;
	localparam int ZW           = 33;
	localparam int Q15_W        = 18;
	localparam int WEIGHT_W     = 16;
	localparam int PROD_W       = 36;
	localparam int SUM_W        = ACCUM_BITS + 1;

	localparam logic signed [XW-1:0] ROT_GAIN = XW'(652032874);

	typedef struct packed {
		logic load;
		logic vector;
	} cordic_ctl_t;

	typedef struct packed {
		logic clear;
		logic map;
		logic mul;
		logic add;
	} acc_ctl_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_ROT   = 9'b000000010,
		ST_MAP   = 9'b000000100,
		ST_MUL   = 9'b000001000,
		ST_ADD   = 9'b000010000,
		ST_NLOAD = 9'b000100000,
		ST_NORM  = 9'b001000000,
		ST_VEC   = 9'b010000000,
		ST_OUTW  = 9'b100000000
	} state_t;

	// atan(2^-i) as a fraction of a full turn, scaled by 2^32.
	function automatic logic [PHASE_BITS-1:0] atan_turns(input logic [TBL_IDX_W-1:0] idx);
		logic [PHASE_BITS-1:0] v;
		case (idx)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: src/weighted_circular_mean_angle.sv
// ----------------------------------------------------------------------------
// Weighted circular mean of angles
// Accumulates weighted sine and cosine of a set of angles and returns the
// angle of the summed vector when the last sample of the set arrives.
// ----------------------------------------------------------------------------
// Each accepted sample passes through rotation in the shared CORDIC unit,
// which runs one micro-rotation per cycle, then quadrant mapping, weighting
// and saturating addition, and returns to idle, where the next request is
// taken; no new sample is taken before then. A sample marked last instead
// goes on to capture the sums, normalize them by shifting one bit a cycle
// (up to 29 bits), load the CORDIC unit, run vectoring in the same unit and
// post the result; a set whose sums are both zero skips the shift, the load
// and the vectoring and yields angle zero. The post step stretches for as
// long as the previous result is still waiting. The result waits in an
// output register while the next set is already being taken in.
module weighted_circular_mean_angle (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,     // use_weights
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,       // [15:0] angle_sample, [31:16] sample_weight
	input  logic        s_tlast,       // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,       // [15:0] mean_angle
	output logic        m_tuser        // [0] sums_saturated
);
	import wcm_pkg::*;

	localparam logic [ACCUM_BITS-1:0] NORM_HI  = ACCUM_BITS'(1) << 30;
	localparam logic [ACCUM_BITS-1:0] NORM_LO  = ACCUM_BITS'(1) << 29;
	localparam logic [ZW-1:0]         HALF_TRN = ZW'(1) << (PHASE_BITS - 1);
	localparam logic [PHASE_BITS-1:0] MEAN_RND = PHASE_BITS'(1) << (PHASE_BITS - 1 - ANGLE_BITS);

	state_t state_q;
	state_t state_d;

	logic                         use_weights_q;
	logic [1:0]                   quad_q;
	logic [WEIGHT_W:0]            weight_q;
	logic                         last_q;
	logic signed [ACCUM_BITS-1:0] nx_q;
	logic signed [ACCUM_BITS-1:0] ny_q;
	logic [ACCUM_BITS-1:0]        nm_q;
	logic                         zero_q;
	logic                         res_sat_q;
	logic                         m_tvalid_q;
	logic [ANGLE_BITS-1:0]        mean_q;
	logic                         m_tuser_q;

	logic [PHASE_BITS-1:0]        phase;
	cordic_ctl_t                  cordic_ctl;
	acc_ctl_t                     acc_ctl;
	logic signed [XW-1:0]         cx_init;
	logic signed [XW-1:0]         cy_init;
	logic [ZW-1:0]                cz_init;
	logic signed [XW-1:0]         cx;
	logic signed [XW-1:0]         cy;
	logic [ZW-1:0]                cz;
	logic                         cordic_done;
	logic signed [ACCUM_BITS-1:0] sine_sum;
	logic signed [ACCUM_BITS-1:0] cosine_sum;
	logic                         acc_sat;
	logic [ACCUM_BITS-1:0]        mag_x;
	logic [ACCUM_BITS-1:0]        mag_y;
	logic                         norm_ok;
	logic signed [XW-1:0]         vx;
	logic signed [XW-1:0]         vy;
	logic [PHASE_BITS-1:0]        z_rnd;
	logic                         slot_free;
	logic                         accept;

	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign phase     = {s_tdata[ANGLE_BITS-1:0], {(PHASE_BITS-ANGLE_BITS){1'b0}}};
	assign mag_x     = cosine_sum[ACCUM_BITS-1] ? -cosine_sum : cosine_sum;
	assign mag_y     = sine_sum[ACCUM_BITS-1] ? -sine_sum : sine_sum;
	assign norm_ok   = (nm_q < NORM_HI) && (nm_q >= NORM_LO);
	assign vx        = XW'(nx_q);
	assign vy        = XW'(ny_q);
	assign z_rnd     = cz[PHASE_BITS-1:0] + MEAN_RND;

	always_comb begin
		cordic_ctl.load   = (state_q == ST_IDLE && s_tvalid) || (state_q == ST_NORM && norm_ok);
		cordic_ctl.vector = (state_q == ST_NORM);
		acc_ctl.map       = (state_q == ST_MAP);
		acc_ctl.mul       = (state_q == ST_MUL);
		acc_ctl.add       = (state_q == ST_ADD);
		acc_ctl.clear     = (state_q == ST_NLOAD);
		if (state_q == ST_IDLE) begin
			cx_init = ROT_GAIN;
			cy_init = '0;
			cz_init = ZW'(phase[PHASE_BITS-3:0]);
		end else if (vx < 0) begin
			// Left half plane: turn the vector by half a turn first.
			cx_init = -vx;
			cy_init = -vy;
			cz_init = HALF_TRN;
		end else begin
			cx_init = vx;
			cy_init = vy;
			cz_init = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_ROT;
			ST_ROT:   if (cordic_done) state_d = ST_MAP;
			ST_MAP:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_ADD;
			ST_ADD:   state_d = last_q ? ST_NLOAD : ST_IDLE;
			ST_NLOAD: begin
				state_d = (sine_sum == '0 && cosine_sum == '0) ? ST_OUTW : ST_NORM;
			end
			ST_NORM:  if (norm_ok) state_d = ST_VEC;
			ST_VEC:   if (cordic_done) state_d = ST_OUTW;
			ST_OUTW:  if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			use_weights_q <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				use_weights_q <= cfg_wdata;
			end
			if (state_q == ST_OUTW && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			quad_q   <= phase[PHASE_BITS-1 -: 2];
			weight_q <= use_weights_q ? {1'b0, s_tdata[16 +: WEIGHT_W]} : (WEIGHT_W+1)'(1);
			last_q   <= s_tlast;
		end
		case (state_q)
			ST_NLOAD: begin
				nx_q      <= cosine_sum;
				ny_q      <= sine_sum;
				nm_q      <= (mag_x > mag_y) ? mag_x : mag_y;
				zero_q    <= (sine_sum == '0 && cosine_sum == '0);
				res_sat_q <= acc_sat;
			end
			ST_NORM: begin
				// Bring the larger magnitude into [2^29, 2^30), one bit a cycle.
				if (nm_q >= NORM_HI) begin
					nx_q <= nx_q >>> 1;
					ny_q <= ny_q >>> 1;
					nm_q <= nm_q >> 1;
				end else if (nm_q < NORM_LO) begin
					nx_q <= nx_q <<< 1;
					ny_q <= ny_q <<< 1;
					nm_q <= nm_q << 1;
				end
			end
			ST_OUTW: begin
				if (slot_free) begin
					mean_q    <= zero_q ? '0 : z_rnd[PHASE_BITS-1 -: ANGLE_BITS];
					m_tuser_q <= res_sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	wcm_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cordic_ctl),
		.x_init (cx_init),
		.y_init (cy_init),
		.z_init (cz_init),
		.x      (cx),
		.y      (cy),
		.z      (cz),
		.done   (cordic_done)
	);

	wcm_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (acc_ctl),
		.x          (cx),
		.y          (cy),
		.quadrant   (quad_q),
		.weight     (weight_q),
		.sine_sum   (sine_sum),
		.cosine_sum (cosine_sum),
		.saturated  (acc_sat)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = 16'(mean_q);
	assign m_tuser  = m_tuser_q;

	// A request is taken only once; the sequencer is busy right after it.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input ready again right after a request");

	// The CORDIC unit finishes only in the rotation or vectoring state.
	a_done_in_cordic_state: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> (state_q == ST_ROT || state_q == ST_VEC))
		else $error("CORDIC finished outside a rotation or vectoring state");

	// Vectoring keeps the vector in the right half plane.
	a_vector_x_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VEC) |-> !cx[XW-1])
		else $error("vectoring x went negative");

	// A result is posted only from the output wait state.
	a_post_from_outw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_OUTW))
		else $error("result posted outside the output wait state");

endmodule

FILE: src/wcm_cordic.sv
// ----------------------------------------------------------------------------
// Shared CORDIC unit
// One micro-rotation per cycle, in rotation mode for sine and cosine or in
// vectoring mode for the arctangent of the accumulated sums.
// ----------------------------------------------------------------------------
module wcm_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wcm_pkg::cordic_ctl_t               ctl,
	input  logic signed [wcm_pkg::XW-1:0]      x_init,
	input  logic signed [wcm_pkg::XW-1:0]      y_init,
	input  logic        [wcm_pkg::ZW-1:0]      z_init,
	output logic signed [wcm_pkg::XW-1:0]      x,
	output logic signed [wcm_pkg::XW-1:0]      y,
	output logic        [wcm_pkg::ZW-1:0]      z,
	output logic                               done
);
	import wcm_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	logic                 busy_q;
	logic                 vec_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic [ZW-1:0]        z_q;

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic [ZW-1:0]        at;
	logic                 up;

	always_comb begin
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		at = {1'b0, atan_turns(TBL_IDX_W'(cnt_q))};
		// Rotation drives the residual angle to zero; vectoring drives y to zero.
		up = vec_q ? y_q[XW-1] : !z_q[ZW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vec_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			vec_q  <= ctl.vector;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
	assign done = busy_q && (cnt_q == CNT_LAST);

endmodule

FILE: src/wcm_accum.sv
// ----------------------------------------------------------------------------
// Weighted sine and cosine accumulator
// Maps the CORDIC result to its quadrant, rounds to Q15, scales by the weight
// and adds into two saturating sums.
// ----------------------------------------------------------------------------
module wcm_accum (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wcm_pkg::acc_ctl_t                     ctl,
	input  logic signed [wcm_pkg::XW-1:0]         x,
	input  logic signed [wcm_pkg::XW-1:0]         y,
	input  logic        [1:0]                     quadrant,
	input  logic        [wcm_pkg::WEIGHT_W:0]     weight,
	output logic signed [wcm_pkg::ACCUM_BITS-1:0] sine_sum,
	output logic signed [wcm_pkg::ACCUM_BITS-1:0] cosine_sum,
	output logic                                  saturated
);
	import wcm_pkg::*;

	localparam logic signed [XW-1:0]         HALF_LSB = XW'(1 << 14);
	localparam logic signed [ACCUM_BITS-1:0] ACC_HI   = {1'b0, {(ACCUM_BITS-1){1'b1}}};
	localparam logic signed [ACCUM_BITS-1:0] ACC_LO   = {1'b1, {(ACCUM_BITS-1){1'b0}}};

	logic signed [XW-1:0]         c_map;
	logic signed [XW-1:0]         s_map;
	logic signed [XW-1:0]         c_rnd;
	logic signed [XW-1:0]         s_rnd;
	logic signed [Q15_W-1:0]      c_s1;
	logic signed [Q15_W-1:0]      s_s1;
	logic signed [PROD_W-1:0]     pc_s2;
	logic signed [PROD_W-1:0]     ps_s2;
	logic signed [SUM_W-1:0]      sum_c;
	logic signed [SUM_W-1:0]      sum_s;
	logic signed [ACCUM_BITS-1:0] next_c;
	logic signed [ACCUM_BITS-1:0] next_s;
	logic                         ovf_c;
	logic                         ovf_s;
	logic signed [ACCUM_BITS-1:0] cos_q;
	logic signed [ACCUM_BITS-1:0] sin_q;
	logic                         sat_q;

	always_comb begin
		case (quadrant)
			2'd0: begin
				c_map = x;
				s_map = y;
			end
			2'd1: begin
				c_map = -y;
				s_map = x;
			end
			2'd2: begin
				c_map = -x;
				s_map = -y;
			end
			default: begin
				c_map = y;
				s_map = -x;
			end
		endcase
		c_rnd = c_map + HALF_LSB;
		s_rnd = s_map + HALF_LSB;
	end

	always_ff @(posedge clk) begin
		if (ctl.map) begin
			c_s1 <= c_rnd[15 +: Q15_W];
			s_s1 <= s_rnd[15 +: Q15_W];
		end
		if (ctl.mul) begin
			pc_s2 <= $signed({1'b0, weight}) * c_s1;
			ps_s2 <= $signed({1'b0, weight}) * s_s1;
		end
	end

	always_comb begin
		sum_c = SUM_W'(cos_q) + SUM_W'(pc_s2);
		sum_s = SUM_W'(sin_q) + SUM_W'(ps_s2);
		// The two top bits of the widened sum differ only on overflow.
		ovf_c = sum_c[SUM_W-1] ^ sum_c[SUM_W-2];
		ovf_s = sum_s[SUM_W-1] ^ sum_s[SUM_W-2];
		if (ovf_c) begin
			next_c = sum_c[SUM_W-1] ? ACC_LO : ACC_HI;
		end else begin
			next_c = sum_c[ACCUM_BITS-1:0];
		end
		if (ovf_s) begin
			next_s = sum_s[SUM_W-1] ? ACC_LO : ACC_HI;
		end else begin
			next_s = sum_s[ACCUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= '0;
			sin_q <= '0;
			sat_q <= 1'b0;
		end else if (ctl.clear) begin
			cos_q <= '0;
			sin_q <= '0;
			sat_q <= 1'b0;
		end else if (ctl.add) begin
			cos_q <= next_c;
			sin_q <= next_s;
			sat_q <= sat_q | ovf_c | ovf_s;
		end
	end

	assign sine_sum   = sin_q;
	assign cosine_sum = cos_q;
	assign saturated  = sat_q;

endmodule

FILE: test/tb_weighted_circular_mean_angle.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted circular mean testbench
// Streams sets of angle samples into the block and predicts every mean angle
// with a bit-exact CORDIC model of its own. Directed extremes come first, then
// random sets in both weighting modes, a full-rate stretch and a long output
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_weighted_circular_mean_angle;

	localparam int     ACC_W          = wcm_pkg::ACCUM_BITS;
	localparam int     N_STEPS        = wcm_pkg::STEPS;
	localparam longint SUM_MAX        = (64'sd1 <<< (ACC_W - 1)) - 1;
	localparam longint SUM_MIN        = -SUM_MAX - 1;
	localparam longint UNIT_GAIN      = 64'sd652032874;
	localparam longint NORM_TOP       = 64'sd1 <<< 30;
	localparam longint NORM_BOTTOM    = 64'sd1 <<< 29;
	localparam int     SETTLE_CYCLES  = 40;
	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     PRINT_LIMIT    = 200;

	typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} quadrant_t;

	typedef struct {
		logic [15:0] mean_angle;
		logic        sums_saturated;
	} mean_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;

	// atan(2^-i) in units of 2^-32 turn.
	longint arctan_turn [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	mean_result_t mean_expected_q [$];
	longint       sine_acc          = 0;
	longint       cosine_acc        = 0;
	bit           acc_clipped       = 1'b0;
	logic         use_weights_model = 1'b0;

	int unsigned  sender_gap_max  = 10;
	int unsigned  sink_stall_max  = 10;
	int unsigned  sink_stall_left = 0;
	int unsigned  sink_hold_left  = 0;
	bit           result_taken    = 1'b0;
	bit           result_waiting  = 1'b0;
	int unsigned  mismatches      = 0;
	int unsigned  idle_cycles     = 0;

	weighted_circular_mean_angle uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic void cordic_sincos(input logic [15:0] angle,
			output longint cos_q, output longint sin_q);
		logic [31:0] phase;
		longint      x, y, z, dx, dy, c, s;
		int          i;
		phase = {angle, 16'h0000};
		x = UNIT_GAIN;
		y = 0;
		z = 0;
		z[29:0] = phase[29:0];
		for (i = 0; i < N_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_turn[i];
			end else begin
				x += dx; y -= dy; z += arctan_turn[i];
			end
		end
		case (quadrant_t'(phase[31:30]))
			Q_FIRST:  begin c = x;  s = y;  end
			Q_SECOND: begin c = -y; s = x;  end
			Q_THIRD:  begin c = -x; s = -y; end
			default:  begin c = y;  s = -x; end
		endcase
		cos_q = (c + 64'sd16384) >>> 15;
		sin_q = (s + 64'sd16384) >>> 15;
	endfunction

	function automatic longint add_clipped(input longint acc, input longint inc);
		if (inc > 0 && acc > SUM_MAX - inc) begin
			acc_clipped = 1'b1;
			return SUM_MAX;
		end
		if (inc < 0 && acc < SUM_MIN - inc) begin
			acc_clipped = 1'b1;
			return SUM_MIN;
		end
		return acc + inc;
	endfunction

	// Angle of (x, y) in units of 2^-32 turn; the origin maps to zero.
	function automatic logic [31:0] cordic_atan2(input longint y_in, input longint x_in);
		longint      x, y, dx, dy, mx, my, m;
		logic [31:0] z;
		int          i;
		x = x_in;
		y = y_in;
		z = '0;
		if (x == 0 && y == 0)
			return '0;
		mx = (x < 0) ? -x : x;
		my = (y < 0) ? -y : y;
		m = (mx > my) ? mx : my;
		while (m >= NORM_TOP) begin
			x = x >>> 1; y = y >>> 1; m = m >>> 1;
		end
		while (m < NORM_BOTTOM) begin
			x = x * 2; y = y * 2; m = m * 2;
		end
		if (x < 0) begin
			x = -x; y = -y; z = 32'h8000_0000;
		end
		for (i = 0; i < N_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += 32'(arctan_turn[i]);
			end else begin
				x -= dx; y += dy; z -= 32'(arctan_turn[i]);
			end
		end
		return z;
	endfunction

	function automatic void predict_sample(input logic [15:0] angle,
			input logic [15:0] weight, input logic last);
		longint       c, s, w;
		logic [32:0]  rounded;
		mean_result_t r;
		cordic_sincos(angle, c, s);
		w = use_weights_model ? {48'd0, weight} : 64'd1;
		sine_acc   = add_clipped(sine_acc, w * s);
		cosine_acc = add_clipped(cosine_acc, w * c);
		if (last) begin
			rounded = {1'b0, cordic_atan2(sine_acc, cosine_acc)} + 33'd32768;
			r.mean_angle     = rounded[31:16];
			r.sums_saturated = acc_clipped;
			mean_expected_q.push_back(r);
			sine_acc    = 0;
			cosine_acc  = 0;
			acc_clipped = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Signals are stable at the falling edge, so a handshake seen here
	// completes at the next rising edge.
	always @(negedge clk) begin : result_check
		mean_result_t want;
		result_taken   = m_tvalid && m_tready;
		result_waiting = m_tvalid;
		if (result_taken) begin
			if (mean_expected_q.size() == 0) begin
				report_mismatch("result with no request pending", m_tdata, 16'h0000);
			end else begin
				want = mean_expected_q.pop_front();
				if (m_tdata !== want.mean_angle)
					report_mismatch("mean_angle", m_tdata, want.mean_angle);
				if (m_tuser !== want.sums_saturated)
					report_mismatch("sums_saturated", {15'd0, m_tuser},
						{15'd0, want.sums_saturated});
			end
		end
	end

	// Per-result stall counts only while a result is waiting; a requested
	// hold-off overrides it.
	always @(posedge clk) begin
		if (result_taken)
			sink_stall_left = $urandom_range(0, sink_stall_max);
		if (sink_hold_left > 0) begin
			sink_hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (sink_stall_left > 0 && result_waiting)
				sink_stall_left--;
			m_tready <= (sink_stall_left == 0);
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("weighted_circular_mean_angle regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Called at a rising edge; returns at the edge where the request is taken.
	// Valid stays high so that a back-to-back request needs no second drive.
	task automatic send_sample(input logic [15:0] angle, input logic [15:0] weight,
			input logic last);
		int unsigned gap;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {weight, angle};
		s_tlast  <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		predict_sample(angle, weight, last);
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'(1 << $urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	// Clustered sets have a meaningful mean; the others are spread at random.
	task automatic send_set(input int unsigned len, input bit clustered);
		logic [15:0] base, angle;
		int unsigned spread, i;
		base   = 16'($urandom);
		spread = 1 << $urandom_range(4, 14);
		for (i = 0; i < len; i++) begin
			if (clustered)
				angle = base + 16'($urandom_range(0, spread)) - 16'(spread >> 1);
			else
				angle = 16'($urandom);
			send_sample(angle, pick_weight(), i == len - 1);
		end
	endtask

	// The block may still be busy with a sample that has no result, so wait
	// out SETTLE_CYCLES after the last result before touching the register.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (mean_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_use_weights(input logic value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		use_weights_model = value;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_extremes();
		write_use_weights(1'b0);
		// Quadrant boundaries and both ends of the angle range; the weight
		// field must have no effect in this mode.
		send_sample(16'h0000, 16'hFFFF, 1'b1);
		send_sample(16'h4000, 16'h0000, 1'b1);
		send_sample(16'h8000, 16'h1234, 1'b1);
		send_sample(16'hC000, 16'hFFFF, 1'b1);
		send_sample(16'hFFFF, 16'h0000, 1'b1);
		send_sample(16'h0001, 16'h8000, 1'b1);
		// Opposite angles cancel exactly, leaving both sums at zero.
		send_sample(16'h2000, 16'h00FF, 1'b0);
		send_sample(16'hA000, 16'hFF00, 1'b1);
		drain_results();

		write_use_weights(1'b1);
		// A zero weight leaves nothing in the sums.
		send_sample(16'h1234, 16'h0000, 1'b1);
		send_sample(16'h7FFF, 16'hFFFF, 1'b1);
		send_sample(16'h8001, 16'h0001, 1'b1);
		send_sample(16'h0000, 16'hFFFF, 1'b0);
		send_sample(16'h8000, 16'h0001, 1'b1);
		send_sample(16'h0000, 16'h0001, 1'b0);
		send_sample(16'h8000, 16'hFFFF, 1'b1);
		send_sample(16'h3000, 16'h8000, 1'b0);
		send_sample(16'hB000, 16'h8000, 1'b1);
		// Mean close to a full turn, where rounding may wrap to zero.
		send_sample(16'hFFF0, 16'hFFFF, 1'b0);
		send_sample(16'h0010, 16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 16'h0001, 1'b1);
		// Accumulator clipping would take about 2^16 full-weight samples in
		// one set, which is far beyond the length of this run.
		drain_results();
	endtask

	task automatic test_random_sets(input logic weighted, input int unsigned gap_max,
			input int unsigned stall_max, input int unsigned n_samples);
		int unsigned sent, len;
		drain_results();
		write_use_weights(weighted);
		sender_gap_max = gap_max;
		sink_stall_max = stall_max;
		sent = 0;
		while (sent < n_samples) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			send_set(len, $urandom_range(0, 3) != 0);
			sent += len;
		end
		drain_results();
	endtask

	task automatic test_full_rate();
		test_random_sets(1'b1, 0, 0, 250);
	endtask

	// With the output held off, finished sets pile up until the block stops
	// taking requests; the sender keeps offering with no gaps.
	task automatic test_output_backpressure();
		drain_results();
		write_use_weights(1'b1);
		sender_gap_max = 0;
		sink_stall_max = 10;
		sink_hold_left = 600;
		repeat (24) send_set($urandom_range(1, 2), 1'b1);
		drain_results();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_random_sets(1'b1, 10, 10, 380);
		test_random_sets(1'b0, 10, 10, 380);
		test_full_rate();
		test_output_backpressure();
		test_random_sets(1'b1, 10, 10, 380);

		drain_results();
		if (mismatches == 0)
			$display("weighted_circular_mean_angle regression: pass");
		else
			$display("weighted_circular_mean_angle regression: fail");
		$finish;
	end

endmodule

FILE: weighted_circular_mean_angle.f
src/wcm_pkg.sv
src/wcm_cordic.sv
src/wcm_accum.sv
src/weighted_circular_mean_angle.sv
test/tb_weighted_circular_mean_angle.sv
